[rtl/htfd_pkg.sv]
// Shared constants, types and the CRC-8 step for the humidity/temperature frame decoder.
package htfd_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [2:0] POS_STATUS = 3'd0;
    localparam logic [2:0] POS_HUM_HI = 3'd1;
    localparam logic [2:0] POS_HUM_MD = 3'd2;
    localparam logic [2:0] POS_SPLIT  = 3'd3;
    localparam logic [2:0] POS_TMP_MD = 3'd4;
    localparam logic [2:0] POS_TMP_LO = 3'd5;
    localparam logic [2:0] POS_CHECK  = 3'd6;

    localparam logic [13:0] HUM_SCALE    = 14'd10000;
    localparam logic [14:0] TMP_SCALE    = 15'd20000;
    localparam logic [15:0] TMP_OFFSET   = 16'd5000;
    localparam int          SCALE_SHIFT  = 20;

    // Completed frame handed from the assembler to the scaling stage
    typedef struct packed {
        logic [7:0]  status;
        logic        crc_ok;
        logic [19:0] hum_raw;
        logic [19:0] tmp_raw;
    } frame_t;

    // One byte through CRC-8, MSB first, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/htfd_assemble.sv]
// Byte position, running CRC and raw field assembly for one response frame.
module htfd_assemble
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           byte_in,
    input  logic                 start_in,
    output logic                 emit,
    output htfd_pkg::frame_t     frame
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  status_reg, status_next;
    logic [19:0] hum_reg, hum_next;
    logic [19:0] tmp_reg, tmp_next;
    logic [2:0]  pos;

    // Effective position: resync on frame start or out-of-range count
    always_comb
    begin
        if (start_in || (pos_reg > htfd_pkg::POS_CHECK))
            pos = htfd_pkg::POS_STATUS;
        else
            pos = pos_reg;
    end

    assign emit          = (pos == htfd_pkg::POS_CHECK);
    assign frame.status  = status_reg;
    assign frame.crc_ok  = (crc_reg == byte_in);
    assign frame.hum_raw = hum_reg;
    assign frame.tmp_raw = tmp_reg;

    // Next state for the current byte
    always_comb
    begin
        pos_next    = pos + 3'd1;
        crc_next    = htfd_pkg::crc8_byte(crc_reg, byte_in);
        status_next = status_reg;
        hum_next    = hum_reg;
        tmp_next    = tmp_reg;
        case (pos)
            htfd_pkg::POS_STATUS:
            begin
                status_next = byte_in;
                crc_next    = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, byte_in);
                hum_next    = '0;
                tmp_next    = '0;
            end
            htfd_pkg::POS_HUM_HI: hum_next = {byte_in, 12'd0};
            htfd_pkg::POS_HUM_MD: hum_next = hum_reg | {8'd0, byte_in, 4'd0};
            htfd_pkg::POS_SPLIT:
            begin
                hum_next = hum_reg | {16'd0, byte_in[7:4]};
                tmp_next = {byte_in[3:0], 16'd0};
            end
            htfd_pkg::POS_TMP_MD: tmp_next = tmp_reg | {4'd0, byte_in, 8'd0};
            htfd_pkg::POS_TMP_LO: tmp_next = tmp_reg | {12'd0, byte_in};
            htfd_pkg::POS_CHECK:
            begin
                pos_next = htfd_pkg::POS_STATUS;
                crc_next = htfd_pkg::CRC_INIT;
            end
            default:
            begin
                pos_next = htfd_pkg::POS_STATUS;
                crc_next = htfd_pkg::CRC_INIT;
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= htfd_pkg::POS_STATUS;
            crc_reg    <= htfd_pkg::CRC_INIT;
            status_reg <= '0;
            hum_reg    <= '0;
            tmp_reg    <= '0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
            hum_reg    <= hum_next;
            tmp_reg    <= tmp_next;
        end
    end

endmodule

[rtl/htfd_scale.sv]
// Scaling to hundredths and the result register with its valid/stall handshake.
module htfd_scale
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  htfd_pkg::frame_t     frame,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic [7:0]           status_byte,
    output logic                 busy_res,
    output logic                 crc_ok,
    output logic [19:0]          humidity_word,
    output logic [19:0]          temperature_word,
    output logic [13:0]          humidity_centi,
    output logic signed [14:0]   temperature_centi
);

    logic        valid_reg, valid_next;
    logic [33:0] hum_prod;
    logic [34:0] tmp_prod;
    logic [14:0] tmp_scaled;
    logic [15:0] tmp_diff;

    // Fixed-point scaling: raw * k >> 20, temperature offset by 50.00 degC
    assign hum_prod   = {14'd0, frame.hum_raw} * {20'd0, htfd_pkg::HUM_SCALE};
    assign tmp_prod   = {15'd0, frame.tmp_raw} * {20'd0, htfd_pkg::TMP_SCALE};
    assign tmp_scaled = tmp_prod[34:htfd_pkg::SCALE_SHIFT];
    assign tmp_diff   = {1'b0, tmp_scaled} - htfd_pkg::TMP_OFFSET;

    // Result valid: set on load, cleared once taken
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_byte       <= frame.status;
            busy_res          <= frame.status[7];
            crc_ok            <= frame.crc_ok;
            humidity_word     <= frame.hum_raw;
            temperature_word  <= frame.tmp_raw;
            humidity_centi    <= hum_prod[33:htfd_pkg::SCALE_SHIFT];
            temperature_centi <= signed'(tmp_diff[14:0]);
        end
    end

    assign result_valid = valid_reg;

endmodule

[rtl/humidity_temp_frame_decoder.sv]
// Top level of the humidity/temperature sensor response frame decoder.
// Takes one frame byte per clock on the byte channel and returns one decoded result
// per seven-byte frame on the result channel. A byte is registered on acceptance,
// decoded from the input register, and a result is valid once its check byte has
// been loaded into the result register. Throughput is one byte per cycle; the byte
// channel stalls only while a check byte sits in the input register behind a result
// that has not been taken, so the result register sets the stall. frame_start
// forces the byte to be the status byte and discards any partial frame.
module humidity_temp_frame_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  logic [7:0]           byte_value,
    input  logic                 frame_start,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [7:0]           status_byte,
    output logic                 busy_res,
    output logic                 crc_ok,
    output logic [19:0]          humidity_word,
    output logic [19:0]          temperature_word,
    output logic [13:0]          humidity_centi,
    output logic signed [14:0]   temperature_centi
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;
    logic             emit;
    logic             blocked;
    logic             fire;
    htfd_pkg::frame_t frame;

    // A check byte waits while the result register is full and stalled
    assign blocked    = emit && result_valid && result_stall;
    assign fire       = in_valid_reg && !blocked;
    assign byte_stall = in_valid_reg && blocked;

    // Input register
    assign in_valid_next = byte_stall ? in_valid_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg  <= byte_value;
            in_start_reg <= frame_start;
        end
    end

    htfd_assemble u_assemble
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .byte_in  (in_byte_reg),
        .start_in (in_start_reg),
        .emit     (emit),
        .frame    (frame)
    );

    htfd_scale u_scale
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (fire && emit),
        .frame             (frame),
        .result_stall      (result_stall),
        .result_valid      (result_valid),
        .status_byte       (status_byte),
        .busy_res          (busy_res),
        .crc_ok            (crc_ok),
        .humidity_word     (humidity_word),
        .temperature_word  (temperature_word),
        .humidity_centi    (humidity_centi),
        .temperature_centi (temperature_centi)
    );

endmodule

[rtl/htfd_checker.sv]
// Port-level checks for the frame decoder and the bind that attaches them.
module htfd_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic                 byte_stall,
    input  logic [7:0]           byte_value,
    input  logic                 frame_start,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic [7:0]           status_byte,
    input  logic                 busy_res,
    input  logic                 crc_ok,
    input  logic [19:0]          humidity_word,
    input  logic [19:0]          temperature_word,
    input  logic [13:0]          humidity_centi,
    input  logic signed [14:0]   temperature_centi
);

    // A stalled result stays valid
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // Busy flag follows status bit 7
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (busy_res == status_byte[7]))
        else $error("busy flag does not match status");

    // Humidity stays below 100.00 percent
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (humidity_centi <= 14'd9999))
        else $error("humidity out of range");

    // Temperature stays within -50.00 .. 149.99 degC
    a_tmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((temperature_centi >= -15'sd5000)
                          && (temperature_centi <= 15'sd14999)))
        else $error("temperature out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

[sim/tb_humidity_temp_frame_decoder.sv]
// Self-checking testbench for the humidity/temperature frame decoder.
module tb_humidity_temp_frame_decoder;

    localparam int unsigned RANDOM_BYTES = 1350;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // One decoded measurement as it leaves the block
    typedef struct packed {
        logic [7:0]         status;
        logic               busy;
        logic               crc_ok;
        logic [19:0]        hum_raw;
        logic [19:0]        tmp_raw;
        logic [13:0]        hum_centi;
        logic signed [14:0] tmp_centi;
    } reading_t;

    // How a stimulus row picks its byte: as written, or the right or wrong check byte
    typedef enum logic [1:0] {CHK_LITERAL, CHK_GOOD, CHK_BAD} check_sel_t;

    typedef struct packed {
        logic [7:0] value;
        logic       start;
        check_sel_t check_sel;
        bit         typed;
        reading_t   want;
    } stim_row_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               byte_valid   = 1'b0;
    logic               byte_stall;
    logic [7:0]         byte_value   = 8'h00;
    logic               frame_start  = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [7:0]         status_byte;
    logic               busy_res;
    logic               crc_ok;
    logic [19:0]        humidity_word;
    logic [19:0]        temperature_word;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;

    // Decoder state mirrored by the predictor
    logic [2:0]  frame_pos    = htfd_pkg::POS_STATUS;
    logic [7:0]  frame_crc    = htfd_pkg::CRC_INIT;
    logic [7:0]  frame_status = 8'h00;
    logic [19:0] hum_acc      = 20'h0;
    logic [19:0] tmp_acc      = 20'h0;

    reading_t    pending_readings[$];
    stim_row_t   stim_table[$];
    int unsigned bytes_sent  = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_run   = 0;
    bit          sender_no_idle = 1'b0;

    always #5 clk = ~clk;

    humidity_temp_frame_decoder u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .byte_value        (byte_value),
        .frame_start       (frame_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status_byte       (status_byte),
        .busy_res          (busy_res),
        .crc_ok            (crc_ok),
        .humidity_word     (humidity_word),
        .temperature_word  (temperature_word),
        .humidity_centi    (humidity_centi),
        .temperature_centi (temperature_centi)
    );

    // CRC-8 over one byte, bit-serial form, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advance the frame decode by one byte; returns 1 when a reading comes out
    function automatic bit decode_frame_byte(input logic [7:0] b, input logic start,
                                             output reading_t r);
        logic [2:0]  pos;
        logic [35:0] hum_scaled;
        logic [35:0] tmp_scaled;
        pos = (start || frame_pos > htfd_pkg::POS_CHECK) ? htfd_pkg::POS_STATUS : frame_pos;
        r = '0;
        decode_frame_byte = 1'b0;
        case (pos)
            htfd_pkg::POS_STATUS:
            begin
                frame_status = b;
                frame_crc    = crc8_step(htfd_pkg::CRC_INIT, b);
                hum_acc      = 20'h0;
                tmp_acc      = 20'h0;
                frame_pos    = htfd_pkg::POS_HUM_HI;
            end
            htfd_pkg::POS_CHECK:
            begin
                hum_scaled  = 36'(hum_acc) * 36'(htfd_pkg::HUM_SCALE);
                tmp_scaled  = 36'(tmp_acc) * 36'(htfd_pkg::TMP_SCALE);
                r.status    = frame_status;
                r.busy      = frame_status[7];
                r.crc_ok    = (frame_crc == b);
                r.hum_raw   = hum_acc;
                r.tmp_raw   = tmp_acc;
                r.hum_centi = 14'(hum_scaled >> htfd_pkg::SCALE_SHIFT);
                r.tmp_centi = 15'((tmp_scaled >> htfd_pkg::SCALE_SHIFT)
                                  - 36'(htfd_pkg::TMP_OFFSET));
                frame_pos   = htfd_pkg::POS_STATUS;
                frame_crc   = htfd_pkg::CRC_INIT;
                decode_frame_byte = 1'b1;
            end
            default:
            begin
                frame_crc = crc8_step(frame_crc, b);
                case (pos)
                    htfd_pkg::POS_HUM_HI: hum_acc = {b, 12'h000};
                    htfd_pkg::POS_HUM_MD: hum_acc = hum_acc | {8'h00, b, 4'h0};
                    htfd_pkg::POS_SPLIT:
                    begin
                        hum_acc = hum_acc | {16'h0000, b[7:4]};
                        tmp_acc = {b[3:0], 16'h0000};
                    end
                    htfd_pkg::POS_TMP_MD: tmp_acc = tmp_acc | {4'h0, b, 8'h00};
                    default:              tmp_acc = tmp_acc | {12'h000, b};
                endcase
                frame_pos = pos + 3'd1;
            end
        endcase
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Byte with extra weight on the extremes
    function automatic logic [7:0] random_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_row(input logic [7:0] v, input logic s, input check_sel_t c,
                           input bit typed = 1'b0, input reading_t want = '0);
        stim_row_t row;
        row.value     = v;
        row.start     = s;
        row.check_sel = c;
        row.typed     = typed;
        row.want      = want;
        stim_table.push_back(row);
    endtask

    // Drive one item, wait for acceptance, then record what it should produce
    task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
                             input reading_t want);
        int unsigned gap;
        reading_t    got;
        gap = sender_no_idle ? 0 : idle_length();
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid  <= 1'b1;
        byte_value  <= b;
        frame_start <= start;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (decode_frame_byte(b, start, got))
        begin
            // typed rows carry their own expected values
            if (typed)
                got = want;
            pending_readings.push_back(got);
        end
        bytes_sent++;
    endtask

    task automatic send_random(input logic [7:0] b, input logic start);
        send_byte(b, start, 1'b0, '0);
    endtask

    // Hold the sender off until every pending reading has come out
    task automatic wait_for_readings();
        if (pending_readings.size() != 0)
        begin
            byte_valid <= 1'b0;
            while (pending_readings.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $error("reading with nothing pending: status_byte %0h", status_byte);
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("status_byte", want.status, status_byte);
                check_field("busy_res", want.busy, busy_res);
                check_field("crc_ok", want.crc_ok, crc_ok);
                check_field("humidity_word", want.hum_raw, humidity_word);
                check_field("temperature_word", want.tmp_raw, temperature_word);
                check_field("humidity_centi", want.hum_centi, humidity_centi);
                check_field("temperature_centi", want.tmp_centi, temperature_centi);
            end
        end
    end

    // Receiver stall: runs of random length, with long quiet stretches
    always @(posedge clk)
    begin
        int unsigned pick;
        if (stall_run != 0)
            stall_run--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                result_stall <= 1'b0;
                stall_run = $urandom_range(0, 8);
            end
            else if (pick < 55)
            begin
                result_stall <= 1'b0;
                stall_run = $urandom_range(40, 200);
            end
            else if (pick < 85)
            begin
                result_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end
            else if (pick < 97)
            begin
                result_stall <= 1'b1;
                stall_run = $urandom_range(3, 10);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_run = $urandom_range(20, 60);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        int unsigned mode;
        int unsigned len;

        // all-zero frame with good CRC: raw values at minimum, temperature at its floor
        add_row(8'h00, 1'b1, CHK_LITERAL);
        for (int i = 0; i < 5; i++)
            add_row(8'h00, 1'b0, CHK_LITERAL);
        add_row(8'h00, 1'b0, CHK_GOOD, 1'b1,
                '{status: 8'h00, busy: 1'b0, crc_ok: 1'b1, hum_raw: 20'h00000,
                  tmp_raw: 20'h00000, hum_centi: 14'd0, tmp_centi: -15'sd5000});
        // partial frame, dropped by a frame start on its second byte
        add_row(8'h55, 1'b0, CHK_LITERAL);
        // all-ones busy frame with a wrong check byte: every field at maximum
        add_row(8'hFF, 1'b1, CHK_LITERAL);
        for (int i = 0; i < 5; i++)
            add_row(8'hFF, 1'b0, CHK_LITERAL);
        add_row(8'h00, 1'b0, CHK_BAD, 1'b1,
                '{status: 8'hFF, busy: 1'b1, crc_ok: 1'b0, hum_raw: 20'hFFFFF,
                  tmp_raw: 20'hFFFFF, hum_centi: 14'd9999, tmp_centi: 15'sd14999});
        // status byte right after a check byte, no frame start; cut at the check position
        add_row(8'h80, 1'b0, CHK_LITERAL);
        add_row(8'h12, 1'b0, CHK_LITERAL);
        add_row(8'h34, 1'b0, CHK_LITERAL);
        add_row(8'h56, 1'b0, CHK_LITERAL);
        add_row(8'h78, 1'b0, CHK_LITERAL);
        add_row(8'h9A, 1'b0, CHK_LITERAL);
        // frame start where the check byte was due: new frame, no reading
        add_row(8'h7F, 1'b1, CHK_LITERAL);
        add_row(8'hA5, 1'b0, CHK_LITERAL);
        add_row(8'h5A, 1'b0, CHK_LITERAL);
        add_row(8'hC3, 1'b0, CHK_LITERAL);
        add_row(8'h3C, 1'b0, CHK_LITERAL);
        add_row(8'h01, 1'b0, CHK_LITERAL);
        add_row(8'h00, 1'b0, CHK_GOOD);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (stim_table[i])
        begin
            row = stim_table[i];
            case (row.check_sel)
                CHK_GOOD: row.value = frame_crc;
                CHK_BAD:  row.value = frame_crc ^ 8'h01;
                default:  ;
            endcase
            send_byte(row.value, row.start, row.typed, row.want);
        end
        wait_for_readings();

        // random frames, broken frames and loose bytes
        while (bytes_sent < stim_table.size() + RANDOM_BYTES)
        begin
            sender_no_idle = ($urandom_range(0, 4) == 0);
            mode = $urandom_range(0, 99);
            if (mode < 70)
            begin
                send_random(random_byte(),
                            (frame_pos != htfd_pkg::POS_STATUS)
                            || ($urandom_range(0, 1) == 1));
                repeat (5) send_random(random_byte(), 1'b0);
                if ($urandom_range(0, 4) != 0)
                    send_random(frame_crc, 1'b0);
                else
                    send_random(random_byte(), 1'b0);
            end
            else if (mode < 82)
            begin
                len = $urandom_range(1, 6);
                send_random(random_byte(), 1'b1);
                repeat (len - 1) send_random(random_byte(), 1'b0);
            end
            else
            begin
                len = $urandom_range(1, 8);
                repeat (len) send_random(random_byte(), $urandom_range(0, 6) == 0);
            end
            if ($urandom_range(0, 49) == 0)
                wait_for_readings();
        end

        // drain and finish
        byte_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/htfd_pkg.sv
rtl/htfd_assemble.sv
rtl/htfd_scale.sv
rtl/humidity_temp_frame_decoder.sv
rtl/htfd_checker.sv
sim/tb_humidity_temp_frame_decoder.sv
